// ----- src/nwvm_pkg.sv -----
package nwvm_pkg;

	localparam int VOICES    = 4;
	localparam int MEM_DEPTH = 65536;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
	// Slot read ahead while slot 0 is processed; the voice ring rotates by one each step.
	localparam int NEXT_SLOT = (VOICES > 1) ? 1 : 0;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_WRITE    = 3'd1,
		OP_START    = 3'd2,
		OP_SET_STEP = 3'd3,
		OP_SET_RUN  = 3'd4
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_VOICE
	} state_t;

	typedef struct packed {
		logic mem_write;
		logic voice_start;
		logic set_step;
		logic set_run;
		logic tick_begin;
		logic voice_proc;
		logic voice_last;
	} cmd_t;

endpackage

// ----- src/nwvm_ctrl.sv -----
module nwvm_ctrl
	import nwvm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	output logic       busy,
	output cmd_t       cmd
);

	state_t              state_q, state_d;
	logic [VIDX_W-1:0]   cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op)
						OP_TICK: begin
							cmd.tick_begin = 1'b1;
							cnt_d          = '0;
							state_d        = ST_VOICE;
						end
						OP_WRITE:    cmd.mem_write   = 1'b1;
						OP_START:    cmd.voice_start = 1'b1;
						OP_SET_STEP: cmd.set_step    = 1'b1;
						OP_SET_RUN:  cmd.set_run     = 1'b1;
						default: ;
					endcase
				end
			end
			ST_VOICE: begin
				busy           = 1'b1;
				cmd.voice_proc = 1'b1;
				if (cnt_q == VIDX_W'(VOICES - 1)) begin
					cmd.voice_last = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/nwvm_datapath.sv -----
module nwvm_datapath
	import nwvm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [1:0]  channel,
	input  logic [15:0] address,
	input  logic [7:0]  byte_value,
	input  logic [15:0] end_address,
	input  logic [15:0] loop_address,
	input  logic        nibble_high,
	input  logic [15:0] increment,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        audio_valid,
	output logic [7:0]  audio_byte
);

	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  rd_data_q;
	logic [15:0] rd_addr;

	logic [15:0] addr_q [VOICES];
	logic [15:0] end_q  [VOICES];
	logic [15:0] loop_q [VOICES];
	logic [15:0] step_q [VOICES];
	logic [7:0]  frac_q [VOICES];
	logic        nib_q  [VOICES];
	logic        run_q  [VOICES];

	logic [15:0] limit_q;
	logic [7:0]  mix_q, pending_q, mix_d;
	logic        valid_q;
	logic [7:0]  audio_q;

	logic [VIDX_W-1:0] chx;
	logic              ch_ok;
	logic [8:0]        frac_sum;
	logic [15:0]       adv_addr, new_addr;
	logic              wrap, new_run;
	logic [3:0]        nib;
	logic [7:0]        sample;

	assign chx   = VIDX_W'(channel);
	assign ch_ok = int'(channel) < VOICES;

	// Sample memory: one write port, one registered read port.
	assign rd_addr = cmd.tick_begin ? addr_q[0] : addr_q[NEXT_SLOT];

	always_ff @(posedge clk) begin
		if (cmd.mem_write)
			mem[address[MEM_AW-1:0]] <= byte_value;
		rd_data_q <= mem[rd_addr[MEM_AW-1:0]];
	end

	// Slot 0 of the ring is the voice being mixed and advanced this cycle.
	assign nib    = nib_q[0] ? rd_data_q[7:4] : rd_data_q[3:0];
	assign sample = run_q[0] ? {{4{nib[3]}}, nib} : 8'd0;
	assign mix_d  = mix_q + sample;

	assign frac_sum = {1'b0, frac_q[0]} + {1'b0, step_q[0][7:0]};
	assign adv_addr = addr_q[0] + 16'(frac_sum[8]) + {8'd0, step_q[0][15:8]};
	assign wrap     = adv_addr >= end_q[0];
	assign new_addr = wrap ? adv_addr - (end_q[0] - loop_q[0]) : adv_addr;
	assign new_run  = !(wrap && (loop_q[0] <= limit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				addr_q[i] <= '0;
				end_q[i]  <= '0;
				loop_q[i] <= '0;
				step_q[i] <= '0;
				frac_q[i] <= '0;
				nib_q[i]  <= 1'b0;
				run_q[i]  <= 1'b0;
			end
		end else if (cmd.voice_proc) begin
			for (int i = 0; i < VOICES - 1; i++) begin
				addr_q[i] <= addr_q[i+1];
				end_q[i]  <= end_q[i+1];
				loop_q[i] <= loop_q[i+1];
				step_q[i] <= step_q[i+1];
				frac_q[i] <= frac_q[i+1];
				nib_q[i]  <= nib_q[i+1];
				run_q[i]  <= run_q[i+1];
			end
			end_q[VOICES-1]  <= end_q[0];
			loop_q[VOICES-1] <= loop_q[0];
			step_q[VOICES-1] <= step_q[0];
			nib_q[VOICES-1]  <= nib_q[0];
			if (run_q[0]) begin
				addr_q[VOICES-1] <= new_addr;
				frac_q[VOICES-1] <= frac_sum[7:0];
				run_q[VOICES-1]  <= new_run;
			end else begin
				addr_q[VOICES-1] <= addr_q[0];
				frac_q[VOICES-1] <= frac_q[0];
				run_q[VOICES-1]  <= 1'b0;
			end
		end else if (ch_ok) begin
			if (cmd.voice_start) begin
				addr_q[chx] <= address;
				end_q[chx]  <= end_address;
				loop_q[chx] <= loop_address;
				step_q[chx] <= increment;
				frac_q[chx] <= '0;
				nib_q[chx]  <= nibble_high;
				run_q[chx]  <= 1'b1;
			end
			if (cmd.set_step)
				step_q[chx] <= increment;
			if (cmd.set_run)
				run_q[chx] <= byte_value[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= 16'd255;
			mix_q     <= '0;
			pending_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= cmd.tick_begin;
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (cmd.tick_begin)
				mix_q <= '0;
			else if (cmd.voice_proc)
				mix_q <= mix_d;
			if (cmd.voice_last)
				pending_q <= mix_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_begin)
			audio_q <= {pending_q[5:0], 2'b00} + 8'd128;
	end

	assign audio_valid = valid_q;
	assign audio_byte  = audio_q;

endmodule

// ----- src/nibble_wavetable_voice_mixer.sv -----
// A tick beat yields its audio_byte strobe in the cycle after it is accepted.
// A tick walks the voices one after another through the single read port of the sample
// memory and holds busy until the walk ends; other commands are taken without a busy period.
// The receiver cannot stall: audio_valid is high for exactly one cycle per tick.
// Reset clears all voices, the pending mix and sets the loop limit to 255;
// sample memory contents stay undefined until written.
module nibble_wavetable_voice_mixer
	import nwvm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [1:0]  channel,
	input  logic [15:0] address,
	input  logic [7:0]  byte_value,
	input  logic [15:0] end_address,
	input  logic [15:0] loop_address,
	input  logic        nibble_high,
	input  logic [15:0] increment,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        audio_valid,
	output logic [7:0]  audio_byte
);

	cmd_t cmd;

	nwvm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.busy   (busy),
		.cmd    (cmd)
	);

	nwvm_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.channel      (channel),
		.address      (address),
		.byte_value   (byte_value),
		.end_address  (end_address),
		.loop_address (loop_address),
		.nibble_high  (nibble_high),
		.increment    (increment),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.audio_valid  (audio_valid),
		.audio_byte   (audio_byte)
	);

	// Every output beat comes in the cycle after an accepted tick.
	a_valid_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		audio_valid |-> $past(start && !busy && op == OP_TICK))
		else $error("audio beat without a preceding tick");

	// An accepted tick always enters the voice walk.
	a_tick_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_TICK) |=> (busy && audio_valid))
		else $error("tick did not start the voice walk");

	// Only a tick can make the block busy.
	a_busy_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && op == OP_TICK))
		else $error("busy raised without a tick");

endmodule
